>>> rtl/bpfa_pkg.sv
`timescale 1ns / 1ps
// Package for the bitmap page frame allocator.
// Holds sizes, field widths, operation codes and the controller state type.
package bpfa_pkg;

    localparam int MAX_PAGES   = 262144;
    localparam int WORD_BITS   = 32;
    localparam int PAGE_BYTES  = 4096;

    localparam int STORE_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_IDX_W  = $clog2(STORE_WORDS);
    localparam int WCNT_W      = WORD_IDX_W + 1;
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int PAGE_IDX_W  = $clog2(MAX_PAGES);
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);

    localparam int CNT_W       = 19;
    localparam int ADDR_W      = 30;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CNT_W-1:0] PAGE_COUNT_RST = CNT_W'(262144);
    localparam logic [CNT_W-1:0] RESERVED_RST   = CNT_W'(32);
    localparam logic [CNT_W-1:0] MAX_PAGES_CNT  = CNT_W'(MAX_PAGES);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGE_COUNT = 1'b0,
        CFG_RESERVED   = 1'b1
    } t_cfg_idx;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REINIT = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_DONE
    } t_state;

endpackage

>>> rtl/bitmap_page_frame_allocator.sv
`timescale 1ns / 1ps
// Bitmap page frame allocator: used-bit store in one RAM, read-modify-write control.
// Depends on bpfa_pkg and bpfa_ram.
//
// Usage:
//   Slave channel s_axis carries one operation per transfer: the operation code
//   in tuser, the byte address for a free in tdata. Every operation returns one
//   transfer on m_axis: the allocated byte address in tdata, out-of-memory in tuser.
//   The configuration port writes page_count (index 0) and reserved_pages
//   (index 1); write only while the block is idle. New values apply from the
//   next operation; a new reserved_pages value reaches the store only on a reinitialise.
//   One operation is in work at a time; s_axis_tready is high when the controller
//   is idle, also while a finished result still waits on m_axis.
//   Operation steps, from input transfer to result valid:
//     allocate   : the scan reads bitmap words from the lowest word that may hold
//                  a free page, one RAM word per cycle; it goes straight to the
//                  result when no word below the page limit can hold one
//     free       : one read-modify-write of the RAM; unused code: straight to the result
//     reinitialise: all 8192 RAM words written, one RAM word per cycle
//   After reset the block runs the same clearing pass with the reset
//   register values and accepts no operation until it ends.
//   When m_axis stalls, the result is held and at most one further finished
//   result waits inside the controller; s_axis then stays not ready.
module bitmap_page_frame_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // [29:0] page_address, [31:30] zero
    input  logic [bpfa_pkg::OP_W-1:0]     s_axis_tuser,  // [1:0] operation
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,  // [29:0] allocated_address,
                                                         // [31:30] zero
    output logic                          m_axis_tuser,  // [0] status
    input  logic                          i_cfg_wen,
    input  logic [bpfa_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [bpfa_pkg::CNT_W-1:0]     i_cfg_wdata
);

    import bpfa_pkg::*;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_page_count, r_reserved;
    logic [WCNT_W-1:0]     r_rd_word, n_rd_word;
    logic [WORD_IDX_W-1:0] r_chk_word, n_chk_word;
    logic                  r_chk_valid, n_chk_valid;
    logic [WCNT_W-1:0]     r_hint, n_hint;
    logic [WORD_IDX_W-1:0] r_clr_word, n_clr_word;
    logic                  r_clr_reply, n_clr_reply;
    logic [WORD_IDX_W-1:0] r_fr_word, n_fr_word;
    logic [BIT_IDX_W-1:0]  r_fr_bit, n_fr_bit;
    logic [ADDR_W-1:0]     r_res_addr, n_res_addr;
    logic                  r_res_status, n_res_status;
    logic                  r_m_valid, n_m_valid;
    logic [ADDR_W-1:0]     r_m_addr, n_m_addr;
    logic                  r_m_status, n_m_status;

    logic                  ram_we;
    logic [WORD_IDX_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;

    logic [CNT_W-1:0]      w_limit, w_res;
    logic [WCNT_W-1:0]     w_nw, w_res_words, w_lim_words;
    logic [WORD_BITS-1:0]  w_vmask, w_free, w_clr_mask;
    logic [BIT_IDX_W-1:0]  w_free_idx;
    logic                  w_s_acc;
    logic [OP_W-1:0]       w_in_op;
    logic [PAGE_IDX_W-1:0] w_in_page;

    bpfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_in_op   = s_axis_tuser;
    assign w_in_page = s_axis_tdata[PAGE_SHIFT +: PAGE_IDX_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_addr};
    assign m_axis_tuser  = r_m_status;

    // saturate counts and derive word counts
    assign w_limit     = (r_page_count > MAX_PAGES_CNT) ? MAX_PAGES_CNT : r_page_count;
    assign w_res       = (r_reserved > MAX_PAGES_CNT) ? MAX_PAGES_CNT : r_reserved;
    assign w_lim_words = WCNT_W'(w_limit >> BIT_IDX_W);
    assign w_res_words = WCNT_W'(w_res >> BIT_IDX_W);
    assign w_nw        = w_lim_words + WCNT_W'(|w_limit[BIT_IDX_W-1:0]);

    assign w_vmask = ({1'b0, r_chk_word} == w_lim_words)
                   ? ((WORD_BITS'(1) << w_limit[BIT_IDX_W-1:0]) - WORD_BITS'(1))
                   : '1;
    assign w_free  = ~ram_rdata & w_vmask;

    always_comb begin
        w_free_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (w_free[b]) begin
                w_free_idx = BIT_IDX_W'(b);
            end
        end
    end

    always_comb begin
        if ({1'b0, r_clr_word} < w_res_words) begin
            w_clr_mask = '1;
        end else if ({1'b0, r_clr_word} == w_res_words) begin
            w_clr_mask = (WORD_BITS'(1) << w_res[BIT_IDX_W-1:0]) - WORD_BITS'(1);
        end else begin
            w_clr_mask = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_page_count <= PAGE_COUNT_RST;
            r_reserved   <= RESERVED_RST;
            r_chk_valid  <= 1'b0;
            r_hint       <= '0;
            r_clr_word   <= '0;
            r_clr_reply  <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk_valid <= n_chk_valid;
            r_hint      <= n_hint;
            r_clr_word  <= n_clr_word;
            r_clr_reply <= n_clr_reply;
            r_m_valid   <= n_m_valid;
            if (i_cfg_wen) begin
                case (i_cfg_addr)
                    CFG_PAGE_COUNT: r_page_count <= i_cfg_wdata;
                    CFG_RESERVED:   r_reserved   <= i_cfg_wdata;
                    default:        r_reserved   <= r_reserved;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_word    <= n_rd_word;
        r_chk_word   <= n_chk_word;
        r_fr_word    <= n_fr_word;
        r_fr_bit     <= n_fr_bit;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_m_addr     <= n_m_addr;
        r_m_status   <= n_m_status;
    end

    always_comb begin
        n_state      = r_state;
        n_rd_word    = r_rd_word;
        n_chk_word   = r_chk_word;
        n_chk_valid  = 1'b0;
        n_hint       = r_hint;
        n_clr_word   = r_clr_word;
        n_clr_reply  = r_clr_reply;
        n_fr_word    = r_fr_word;
        n_fr_bit     = r_fr_bit;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_m_valid    = r_m_valid && !m_axis_tready;
        n_m_addr     = r_m_addr;
        n_m_status   = r_m_status;
        ram_we       = 1'b0;
        ram_waddr    = r_chk_word;
        ram_wdata    = ram_rdata;
        ram_raddr    = r_rd_word[WORD_IDX_W-1:0];

        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_word;
                ram_wdata  = w_clr_mask;
                n_clr_word = r_clr_word + WORD_IDX_W'(1);
                if (r_clr_word == WORD_IDX_W'(STORE_WORDS - 1)) begin
                    n_hint       = w_res_words;
                    n_clr_reply  = 1'b0;
                    n_res_addr   = '0;
                    n_res_status = 1'b0;
                    n_state      = r_clr_reply ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_s_acc) begin
                    n_res_addr   = '0;
                    n_res_status = 1'b0;
                    case (w_in_op)
                        OP_ALLOC: begin
                            if (r_hint >= w_nw) begin
                                n_res_status = 1'b1;
                                n_state      = ST_DONE;
                            end else begin
                                n_rd_word = r_hint;
                                n_state   = ST_SCAN;
                            end
                        end
                        OP_FREE: begin
                            n_fr_word = w_in_page[PAGE_IDX_W-1:BIT_IDX_W];
                            n_fr_bit  = w_in_page[BIT_IDX_W-1:0];
                            n_state   = ST_FREE_RD;
                        end
                        OP_REINIT: begin
                            n_clr_word  = '0;
                            n_clr_reply = 1'b1;
                            n_state     = ST_CLEAR;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // issue the next word while checking the one that arrived
                if (r_rd_word < w_nw) begin
                    n_rd_word   = r_rd_word + WCNT_W'(1);
                    n_chk_word  = r_rd_word[WORD_IDX_W-1:0];
                    n_chk_valid = 1'b1;
                end
                if (r_chk_valid) begin
                    if (|w_free) begin
                        ram_we      = 1'b1;
                        ram_waddr   = r_chk_word;
                        ram_wdata   = ram_rdata | (WORD_BITS'(1) << w_free_idx);
                        n_res_addr  = ADDR_W'({r_chk_word, w_free_idx}) << PAGE_SHIFT;
                        n_hint      = {1'b0, r_chk_word};
                        n_chk_valid = 1'b0;
                        n_state     = ST_DONE;
                    end else if (({1'b0, r_chk_word} + WCNT_W'(1)) >= w_nw) begin
                        n_res_status = 1'b1;
                        n_hint       = w_lim_words;
                        n_chk_valid  = 1'b0;
                        n_state      = ST_DONE;
                    end
                end
            end
            ST_FREE_RD: begin
                ram_raddr = r_fr_word;
                n_state   = ST_FREE_WR;
            end
            ST_FREE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_fr_word;
                ram_wdata = ram_rdata & ~(WORD_BITS'(1) << r_fr_bit);
                if ({1'b0, r_fr_word} < r_hint) begin
                    n_hint = {1'b0, r_fr_word};
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_addr   = r_res_addr;
                    n_m_status = r_res_status;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hint <= WCNT_W'(STORE_WORDS))
        else $error("allocation hint beyond store");

    a_ram_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_CLEAR || r_state == ST_SCAN || r_state == ST_FREE_WR))
        else $error("store written outside a write phase");

    a_oom_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_m_status) |-> (r_m_addr == '0))
        else $error("out-of-memory result carries an address");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state != ST_IDLE))
        else $error("accepted operation not started");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_chk_valid) |-> ({1'b0, r_chk_word} < w_nw))
        else $error("scan checks a word beyond the page limit");

endmodule

>>> rtl/bpfa_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_page_frame_allocator: directed and random
// allocate/free/reinitialise traffic against an in-bench bitmap predictor.
// Depends on bpfa_pkg and the allocator RTL.
module tb;
    import bpfa_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              oom;
    } t_frame_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;  // [29:0] page_address, [31:30] zero
    logic [OP_W-1:0]   s_axis_tuser = '0;  // [1:0] operation
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;       // [29:0] allocated_address, [31:30] zero
    logic              m_axis_tuser;       // [0] status
    logic              i_cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [CNT_W-1:0]  i_cfg_wdata = '0;

    logic [WORD_BITS-1:0] used_words [STORE_WORDS];
    logic [CNT_W-1:0]  cfg_page_count;
    logic [CNT_W-1:0]  cfg_reserved;
    int unsigned       granted_pages [$];
    t_frame_result     frame_results_due [$];
    t_frame_result     head_result;

    int unsigned       snd_idle_pct = 0;
    int unsigned       rcv_stall_pct = 0;
    int unsigned       hold_left = 0;
    int unsigned       fail_count = 0;
    int unsigned       cycle_count = 0;

    bitmap_page_frame_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // hold off for the requested stretch, otherwise stall at random
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (frame_results_due.size() == 0) begin
                $display("%0t: unexpected transfer, got addr %h status %b", $time,
                         m_axis_tdata[29:0], m_axis_tuser);
                fail_count++;
            end else begin
                head_result = frame_results_due.pop_front();
                if (m_axis_tdata[29:0] !== head_result.addr) begin
                    $display("%0t: allocated_address expected %h got %h", $time,
                             head_result.addr, m_axis_tdata[29:0]);
                    fail_count++;
                end
                if (m_axis_tuser !== head_result.oom) begin
                    $display("%0t: status expected %b got %b", $time,
                             head_result.oom, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    function automatic int unsigned clamp_count(input logic [CNT_W-1:0] n);
        return (n > MAX_PAGES) ? MAX_PAGES : int'(n);
    endfunction

    function automatic void reload_store();
        int unsigned n;
        n = clamp_count(cfg_reserved);
        foreach (used_words[w]) begin
            if ((w + 1) * WORD_BITS <= n)
                used_words[w] = '1;
            else if (w * WORD_BITS < n)
                used_words[w] = (32'd1 << (n - w * WORD_BITS)) - 32'd1;
            else
                used_words[w] = '0;
        end
        granted_pages.delete();
    endfunction

    function automatic t_frame_result predict_frame_op(input t_op op,
                                                       input logic [ADDR_W-1:0] addr);
        t_frame_result r;
        int unsigned   limit;
        int unsigned   page;
        bit            found;
        r = '0;
        case (op)
            OP_ALLOC: begin
                limit = clamp_count(cfg_page_count);
                page = 0;
                found = 1'b0;
                while (!found && page < limit) begin
                    if (used_words[page / WORD_BITS] == '1)
                        page += WORD_BITS;
                    else if (!used_words[page / WORD_BITS][page % WORD_BITS])
                        found = 1'b1;
                    else
                        page++;
                end
                if (found) begin
                    used_words[page / WORD_BITS][page % WORD_BITS] = 1'b1;
                    granted_pages.push_back(page);
                    r.addr = ADDR_W'(page * PAGE_BYTES);
                end else begin
                    r.oom = 1'b1;
                end
            end
            OP_FREE: begin
                page = addr / PAGE_BYTES;
                if (page < MAX_PAGES)
                    used_words[page / WORD_BITS][page % WORD_BITS] = 1'b0;
            end
            OP_REINIT: reload_store();
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_op(input t_op op, input logic [ADDR_W-1:0] addr);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < snd_idle_pct)
            gap++;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, addr};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        frame_results_due.push_back(predict_frame_op(op, addr));
    endtask

    task automatic free_page(input int unsigned page);
        send_op(OP_FREE, ADDR_W'(page * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1)));
    endtask

    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (frame_results_due.size() != 0);
    endtask

    // call only with the block idle
    task automatic set_limits(input logic [CNT_W-1:0] count, input logic [CNT_W-1:0] reserved);
        i_cfg_wen   <= 1'b1;
        i_cfg_addr  <= CFG_PAGE_COUNT;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        cfg_page_count = count;
        i_cfg_addr  <= CFG_RESERVED;
        i_cfg_wdata <= reserved;
        @(posedge i_clk);
        cfg_reserved = reserved;
        i_cfg_wen   <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_op(OP_ALLOC, '0);
        send_op(OP_ALLOC, 30'h3FFF_FFFF);
        send_op(OP_FREE, 30'h0002_0FFF);
        send_op(OP_ALLOC, '0);
        send_op(OP_FREE, '0);
        send_op(OP_ALLOC, 30'h1555_5555);
        free_page(40);
        send_op(OP_FREE, 30'h3FFF_FFFF);
        send_op(OP_NONE, 30'h3FFF_FFFF);
        send_op(OP_ALLOC, '0);
        wait_results_done();
    endtask

    task automatic test_register_extremes();
        set_limits('0, '0);
        send_op(OP_REINIT, '0);
        send_op(OP_ALLOC, '0);
        wait_results_done();
        set_limits(19'd33, 19'd32);
        send_op(OP_REINIT, 30'h2AAA_AAAA);
        send_op(OP_ALLOC, '0);
        send_op(OP_ALLOC, '0);
        free_page(32);
        send_op(OP_ALLOC, '0);
        wait_results_done();
        set_limits(19'd40, 19'd100);
        send_op(OP_REINIT, '0);
        send_op(OP_ALLOC, '0);
        free_page(50);
        send_op(OP_ALLOC, '0);
        free_page(39);
        send_op(OP_ALLOC, '0);
        wait_results_done();
        set_limits('1, '1);
        send_op(OP_REINIT, '0);
        send_op(OP_ALLOC, '0);
        send_op(OP_FREE, 30'h3FFF_FABC);
        send_op(OP_ALLOC, '0);
        wait_results_done();
        // store stays full until the next reinitialise
        set_limits(MAX_PAGES_CNT, '0);
        send_op(OP_ALLOC, '0);
        send_op(OP_REINIT, '0);
        send_op(OP_ALLOC, '0);
        wait_results_done();
    endtask

    task automatic test_backpressure();
        set_limits(19'd200, 19'd16);
        send_op(OP_REINIT, '0);
        wait_results_done();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        @(negedge i_clk);
        hold_left = 300;
        @(posedge i_clk);
        for (int unsigned i = 0; i < 24; i++) begin
            if (i % 3 == 2)
                free_page(16 + $urandom_range(20));
            else
                send_op(OP_ALLOC, 30'($urandom));
        end
        wait_results_done();
    endtask

    task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                       input int unsigned n_items);
        int unsigned sel;
        int unsigned count;
        int unsigned reserved;
        int unsigned idx;
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i % 50 == 0) begin
                wait_results_done();
                case ($urandom_range(5))
                    0: begin
                        count = $urandom_range(1, 96);
                        reserved = $urandom_range(0, count + 8);
                    end
                    1: begin
                        count = $urandom_range(97, 700);
                        reserved = $urandom_range(0, count / 2);
                    end
                    2: begin
                        count = MAX_PAGES;
                        reserved = $urandom_range(0, 300);
                    end
                    3: begin
                        count = $urandom_range(MAX_PAGES + 1, 19'h7FFFF);
                        reserved = $urandom_range(0, 64);
                    end
                    4: begin
                        count = $urandom_range(1, 600);
                        reserved = $urandom_range(count, 19'h7FFFF);
                    end
                    default: begin
                        count = WORD_BITS * $urandom_range(1, 20);
                        reserved = 0;
                    end
                endcase
                set_limits(CNT_W'(count), CNT_W'(reserved));
                send_op(OP_REINIT, 30'($urandom));
            end
            sel = $urandom_range(99);
            if (sel < 50) begin
                send_op(OP_ALLOC, 30'($urandom));
            end else if (sel < 80 && granted_pages.size() != 0) begin
                idx = $urandom_range(granted_pages.size() - 1);
                free_page(granted_pages[idx]);
                granted_pages.delete(idx);
            end else if (sel < 90) begin
                free_page($urandom_range(0, clamp_count(cfg_page_count) + 40) % MAX_PAGES);
            end else if (sel < 95) begin
                send_op(OP_FREE, 30'($urandom));
            end else if (sel < 98) begin
                send_op(OP_NONE, 30'($urandom));
            end else begin
                send_op(OP_REINIT, 30'($urandom));
            end
        end
        wait_results_done();
    endtask

    initial begin
        cfg_page_count = PAGE_COUNT_RST;
        cfg_reserved   = RESERVED_RST;
        reload_store();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_register_extremes();
        test_backpressure();
        test_random_traffic(0, 0, 200);
        test_random_traffic(61, 0, 200);
        test_random_traffic(0, 61, 200);
        test_random_traffic(9, 9, 200);

        wait_results_done();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
